FILE: hdl/pctd_pkg.sv
// pctd_pkg: shared types and constants for the trial-division prime counter
// no dependencies; used by the stream interfaces and the top level
`default_nettype none

package pctd_pkg;

  localparam int unsigned CandFieldW = 32;
  localparam int unsigned TallyW     = 32;
  localparam int unsigned ValueBitsDefault = 32;

  typedef struct packed {
    logic [CandFieldW-1:0] candidate;
    logic                  restart;
  } cand_t;

  typedef struct packed {
    logic              is_prime;
    logic [TallyW-1:0] prime_total;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/pctd_if.sv
// pctd_if: valid/ready stream interfaces for candidates and results
// depends on pctd_pkg for the payload types
`default_nettype none

interface pctd_in_if;
  logic                valid;
  logic                ready;
  pctd_pkg::cand_t     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pctd_out_if;
  logic                valid;
  logic                ready;
  pctd_pkg::result_t   data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/prime_count_trial_division_top.sv
// prime_count_trial_division_top: primality test by trial division, running prime count
// depends on pctd_pkg and the stream interfaces in pctd_if
//
// Usage: candidates arrive on in_i (candidate, restart) and each transaction gives exactly
// one result on out_o (is_prime, prime_total), in order. A transaction completes at a
// rising edge with valid and ready both high.
// Only the low VALUE_BITS bits of the candidate are tested (at most 32).
// Values 0 to 3 and even values are settled at acceptance, without trial division. Otherwise odd
// divisors d = 3, 5, ... are tried while d*d <= value; each remainder is formed bit-serially
// by one restoring subtract per cycle. One candidate is worked on at a time.
// The result sits in an output register: the next candidate is taken while it waits, but
// that candidate cannot finish until the receiver has taken the earlier result.
// restart clears the count before its candidate is counted; the count saturates at its
// maximum. Reset empties the block, drops any pending result and clears the count.
`default_nettype none

module prime_count_trial_division_top #(
  parameter int unsigned VALUE_BITS = pctd_pkg::ValueBitsDefault
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  pctd_in_if.sink           in_i,
  pctd_out_if.source        out_o
);

  localparam int unsigned CandW = (VALUE_BITS < pctd_pkg::CandFieldW) ?
                                  VALUE_BITS : pctd_pkg::CandFieldW;
  localparam int unsigned HalfW = (CandW + 1) / 2 + 1;
  localparam int unsigned SqW   = CandW + 2;
  localparam int unsigned CntW  = $clog2(CandW);
  localparam int unsigned TallyW = pctd_pkg::TallyW;

  typedef enum logic [1:0] {
    StIdle,
    StCheck,
    StDiv,
    StDone
  } state_e;

  state_e               state_q;
  logic [CandW-1:0]     n_q;
  logic [CandW-1:0]     shift_q;
  logic [HalfW-1:0]     d_q;
  logic [HalfW-1:0]     rem_q;
  logic [SqW-1:0]       sq_q;
  logic [CntW-1:0]      cnt_q;
  logic                 restart_q;
  logic                 prime_q;
  logic [TallyW-1:0]    tally_q;
  logic                 out_valid_q;
  pctd_pkg::result_t    out_data_q;

  logic [CandW-1:0]     cand_n;
  logic [HalfW:0]       rem_sh;
  logic [HalfW-1:0]     rem_d;
  logic [TallyW-1:0]    tally_base;
  logic [TallyW-1:0]    tally_d;
  logic                 in_fire;
  logic                 out_free;
  logic                 out_load;

  assign cand_n   = in_i.data.candidate[CandW-1:0];
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign out_load = (state_q == StDone) && out_free;

  assign in_i.ready  = (state_q == StIdle);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // one restoring division step: bring in the next dividend bit
  always_comb begin
    rem_sh = {rem_q, shift_q[CandW-1]};
    if (rem_sh >= {1'b0, d_q}) begin
      rem_d = HalfW'(rem_sh - {1'b0, d_q});
    end else begin
      rem_d = rem_sh[HalfW-1:0];
    end
  end

  // saturating tally, cleared first on restart
  always_comb begin
    tally_base = restart_q ? '0 : tally_q;
    if (prime_q && (tally_base != {TallyW{1'b1}})) begin
      tally_d = tally_base + TallyW'(1);
    end else begin
      tally_d = tally_base;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      tally_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_fire) begin
            restart_q <= in_i.data.restart;
            n_q       <= cand_n;
            d_q       <= HalfW'(3);
            sq_q      <= SqW'(9);
            priority if (cand_n < CandW'(2)) begin
              prime_q <= 1'b0;
              state_q <= StDone;
            end else if (cand_n < CandW'(4)) begin
              prime_q <= 1'b1;
              state_q <= StDone;
            end else if (!cand_n[0]) begin
              prime_q <= 1'b0;
              state_q <= StDone;
            end else begin
              state_q <= StCheck;
            end
          end
        end
        StCheck: begin
          if (sq_q > SqW'(n_q)) begin
            prime_q <= 1'b1;
            state_q <= StDone;
          end else begin
            shift_q <= n_q;
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= StDiv;
          end
        end
        StDiv: begin
          shift_q <= shift_q << 1;
          rem_q   <= rem_d;
          cnt_q   <= cnt_q + CntW'(1);
          if (cnt_q == CntW'(CandW - 1)) begin
            if (rem_d == '0) begin
              prime_q <= 1'b0;
              state_q <= StDone;
            end else begin
              // (d+2)^2 = d^2 + 4d + 4
              d_q     <= d_q + HalfW'(2);
              sq_q    <= sq_q + (SqW'(d_q) << 2) + SqW'(4);
              state_q <= StCheck;
            end
          end
        end
        StDone: begin
          if (out_free) begin
            out_data_q.is_prime    <= prime_q;
            out_data_q.prime_total <= tally_d;
            tally_q                <= tally_d;
            state_q                <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // divisor stays odd and at least three while dividing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> (d_q[0] && (d_q >= HalfW'(3))))
    else $error("trial divisor not odd or below three");

  // the incremental square tracks the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StCheck) || (state_q == StDiv)) |->
      (64'(sq_q) == 64'(d_q) * 64'(d_q)))
    else $error("divisor square out of step");

  // without restart the tally never falls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StDone) && out_free && !restart_q) |=> (tally_q >= $past(tally_q)))
    else $error("prime tally decreased");

  // a pending result is never overwritten before it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(out_data_q)))
    else $error("pending result lost");

  // a result is loaded only by finishing a candidate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_q)) |-> ($past(state_q) == StDone))
    else $error("result without a finished candidate");

endmodule

`default_nettype wire
